// ===== hdl/fwk_pkg.sv =====
`timescale 1ns / 1ps

package fwk_pkg;

   // Item field widths
   localparam int DATA_W = 32;
   localparam int IDX_W  = 11;
   localparam int CMD_W  = 2;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SET   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

   // Result status codes
   localparam logic STATUS_DONE  = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

   // Register map
   localparam int                 CSR_ADDR_W = 3;
   localparam logic               CSR_IDX_SIZE = 1'b0;
   localparam logic [IDX_W-1:0]   SIZE_RESET = 11'd1024;

   // Sequencer states
   typedef enum logic [6:0] {
      S_CLEAR  = 7'b0000001,
      S_IDLE   = 7'b0000010,
      S_DELTA  = 7'b0000100,
      S_UPD    = 7'b0001000,
      S_QLAST  = 7'b0010000,
      S_QFIRST = 7'b0100000,
      S_RESP   = 7'b1000000
   } state_type;

endpackage

// ===== hdl/fwk_store.sv =====
`timescale 1ns / 1ps

module fwk_store #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic                       clock,
   input  logic                       tree_we,
   input  logic [AW-1:0]              tree_waddr,
   input  logic [fwk_pkg::DATA_W-1:0] tree_wdata,
   input  logic [AW-1:0]              tree_raddr,
   output logic [fwk_pkg::DATA_W-1:0] tree_rdata,
   input  logic                       plain_we,
   input  logic [AW-1:0]              plain_waddr,
   input  logic [fwk_pkg::DATA_W-1:0] plain_wdata,
   input  logic [AW-1:0]              plain_raddr,
   output logic [fwk_pkg::DATA_W-1:0] plain_rdata
);
   import fwk_pkg::*;

   logic [DATA_W-1:0] tree_mem  [DEPTH];
   logic [DATA_W-1:0] plain_mem [DEPTH];
   logic [DATA_W-1:0] tree_rd_ff;
   logic [DATA_W-1:0] plain_rd_ff;

   // partial sums: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (tree_we) begin
         tree_mem[tree_waddr] <= tree_wdata;
      end
      tree_rd_ff <= tree_mem[tree_raddr];
   end

   // shadow of the plain values
   always_ff @(posedge clock) begin
      if (plain_we) begin
         plain_mem[plain_waddr] <= plain_wdata;
      end
      plain_rd_ff <= plain_mem[plain_raddr];
   end

   assign tree_rdata  = tree_rd_ff;
   assign plain_rdata = plain_rd_ff;

endmodule

// ===== hdl/fenwick_point_set_range_sum.sv =====
`timescale 1ns / 1ps

// Fenwick tree over MAX_ENTRIES signed 32-bit values (one-based), with clear, point set
// and range sum commands; one result item per input item, sums wrap modulo 2^32. Items
// are taken one at a time; req_ready is high only while the sequencer is idle and no
// result waits in the output register. A query walks the tree twice (last index, then
// first index minus one), one tree read per cycle with reads overlapped with the adds.
// A set reads the old value, forms the delta, then does one read-modify-write per step
// of the upward walk. A single 32-bit add/subtract unit does all arithmetic on the
// data values. Flagged items and unused commands answer in the cycle after they are
// taken. Every result then waits in the result register until it is taken, and the
// sequencer returns to idle before the next item is taken. After reset, and for each
// clear command, both stores are swept one entry per cycle while no item is accepted;
// register writes are taken at any time.
// Register 0 (address 0) is size_in_use, reset 1024.
module fenwick_point_set_range_sum #(
   parameter int MAX_ENTRIES = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   // input item channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [fwk_pkg::CMD_W-1:0]          req_cmd,
   input  logic [fwk_pkg::IDX_W-1:0]          req_first_index,
   input  logic [fwk_pkg::IDX_W-1:0]          req_last_index,
   input  logic signed [fwk_pkg::DATA_W-1:0]  req_new_value,
   // result item channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [fwk_pkg::DATA_W-1:0]  rsp_range_sum,
   output logic                               rsp_status,
   // register port
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [fwk_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [31:0]                        pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready
);
   import fwk_pkg::*;

   localparam int AW = $clog2(MAX_ENTRIES);
   localparam int PW = $clog2(2 * MAX_ENTRIES + 1);
   localparam logic [AW-1:0] CLR_LAST = AW'(MAX_ENTRIES - 1);
   localparam logic [PW-1:0] POS_MAX  = PW'(MAX_ENTRIES);

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  size_ff, size_in;
   logic [PW-1:0]     pos_ff, pos_in;
   logic              pend_ff, pend_in;
   logic [AW-1:0]     waddr_ff, waddr_in;
   logic [AW-1:0]     clr_ff, clr_in;
   logic              clr_rsp_ff, clr_rsp_in;
   logic [DATA_W-1:0] acc_ff, acc_in;
   logic [DATA_W-1:0] delta_ff, delta_in;
   logic [IDX_W-1:0]  first_ff, first_in;
   logic [DATA_W-1:0] val_ff, val_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_sum_ff, rsp_sum_in;
   logic              rsp_status_ff, rsp_status_in;

   logic              tree_we, plain_we;
   logic [AW-1:0]     tree_waddr, tree_raddr, plain_waddr, plain_raddr;
   logic [DATA_W-1:0] tree_wdata, plain_wdata, tree_rd, plain_rd;

   logic [DATA_W-1:0] add_a, add_b, add_res;
   logic              add_sub;

   logic              first_ok, last_ok, pos_live;
   logic [PW-1:0]     pos_low, pos_strip;

   fwk_store #(
      .DEPTH (MAX_ENTRIES),
      .AW    (AW)
   ) u_store (
      .clock       (clock),
      .tree_we     (tree_we),
      .tree_waddr  (tree_waddr),
      .tree_wdata  (tree_wdata),
      .tree_raddr  (tree_raddr),
      .tree_rdata  (tree_rd),
      .plain_we    (plain_we),
      .plain_waddr (plain_waddr),
      .plain_wdata (plain_wdata),
      .plain_raddr (plain_raddr),
      .plain_rdata (plain_rd)
   );

   // register port
   assign pready = 1'b1;
   assign prdata = 32'(size_ff);

   always_comb begin
      size_in = size_ff;
      if (psel && penable && pwrite && paddr[2] == CSR_IDX_SIZE) begin
         size_in = pwdata[IDX_W-1:0];
      end
   end

   // index range checks against the size in use, capped at the store depth
   assign first_ok = (req_first_index != '0) && (req_first_index <= size_ff) &&
                     (32'(req_first_index) <= 32'(MAX_ENTRIES));
   assign last_ok  = (req_last_index != '0) && (req_last_index <= size_ff) &&
                     (32'(req_last_index) <= 32'(MAX_ENTRIES));

   // walk helpers: lowest set bit upward, strip lowest set bit downward
   assign pos_live  = (pos_ff != '0) && (pos_ff <= POS_MAX);
   assign pos_low   = pos_ff & (~pos_ff + 1'b1);
   assign pos_strip = pos_ff & (pos_ff - 1'b1);

   // shared add/subtract unit
   always_comb begin
      add_a   = acc_ff;
      add_b   = tree_rd;
      add_sub = 1'b0;
      case (state_ff)
         S_DELTA: begin
            add_a   = val_ff;
            add_b   = plain_rd;
            add_sub = 1'b1;
         end
         S_UPD: begin
            add_a = tree_rd;
            add_b = delta_ff;
         end
         S_QFIRST: begin
            add_sub = 1'b1;
         end
         default: begin
            add_sub = 1'b0;
         end
      endcase
   end

   assign add_res = add_a + (add_sub ? ~add_b : add_b) + DATA_W'(add_sub);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      pend_in       = 1'b0;
      waddr_in      = waddr_ff;
      clr_in        = clr_ff;
      clr_rsp_in    = clr_rsp_ff;
      acc_in        = acc_ff;
      delta_in      = delta_ff;
      first_in      = first_ff;
      val_in        = val_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_sum_in    = rsp_sum_ff;
      rsp_status_in = rsp_status_ff;

      tree_we     = 1'b0;
      tree_waddr  = waddr_ff;
      tree_wdata  = add_res;
      tree_raddr  = AW'(pos_ff - 1'b1);
      plain_we    = 1'b0;
      plain_waddr = AW'(first_ff - 1'b1);
      plain_wdata = val_ff;
      plain_raddr = AW'(req_first_index - 1'b1);

      case (state_ff)
         S_CLEAR: begin
            tree_we     = 1'b1;
            plain_we    = 1'b1;
            tree_waddr  = clr_ff;
            plain_waddr = clr_ff;
            tree_wdata  = '0;
            plain_wdata = '0;
            if (clr_ff == CLR_LAST) begin
               clr_rsp_in = 1'b0;
               if (clr_rsp_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_sum_in    = '0;
                  rsp_status_in = STATUS_DONE;
                  state_in      = S_RESP;
               end else begin
                  state_in = S_IDLE;
               end
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               // default answer: immediate result, sum zero
               rsp_sum_in    = '0;
               rsp_status_in = STATUS_DONE;
               case (req_cmd)
                  CMD_CLEAR: begin
                     clr_in     = '0;
                     clr_rsp_in = 1'b1;
                     state_in   = S_CLEAR;
                  end
                  CMD_SET: begin
                     if (first_ok) begin
                        first_in = req_first_index;
                        val_in   = req_new_value;
                        state_in = S_DELTA;
                     end else begin
                        rsp_status_in = STATUS_RANGE;
                        rsp_valid_in  = 1'b1;
                        state_in      = S_RESP;
                     end
                  end
                  CMD_QUERY: begin
                     if (first_ok && last_ok) begin
                        first_in = req_first_index;
                        pos_in   = PW'(req_last_index);
                        acc_in   = '0;
                        state_in = S_QLAST;
                     end else begin
                        rsp_status_in = STATUS_RANGE;
                        rsp_valid_in  = 1'b1;
                        state_in      = S_RESP;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     state_in     = S_RESP;
                  end
               endcase
            end
         end
         S_DELTA: begin
            // old value is in; form delta and store the new value
            delta_in = add_res;
            plain_we = 1'b1;
            pos_in   = PW'(first_ff);
            state_in = S_UPD;
         end
         S_UPD: begin
            // write back the entry read last cycle, read the next one
            if (pend_ff) begin
               tree_we = 1'b1;
            end
            if (pos_live) begin
               pend_in  = 1'b1;
               waddr_in = AW'(pos_ff - 1'b1);
               pos_in   = pos_ff + pos_low;
            end else if (!pend_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_sum_in    = '0;
               rsp_status_in = STATUS_DONE;
               state_in      = S_RESP;
            end
         end
         S_QLAST: begin
            if (pend_ff) begin
               acc_in = add_res;
            end
            if (pos_ff != '0) begin
               pend_in = 1'b1;
               pos_in  = pos_strip;
            end else if (!pend_ff) begin
               pos_in   = PW'(first_ff - 1'b1);
               state_in = S_QFIRST;
            end
         end
         S_QFIRST: begin
            if (pend_ff) begin
               acc_in = add_res;
            end
            if (pos_ff != '0) begin
               pend_in = 1'b1;
               pos_in  = pos_strip;
            end else if (!pend_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_sum_in    = acc_ff;
               rsp_status_in = STATUS_DONE;
               state_in      = S_RESP;
            end
         end
         S_RESP: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         size_ff      <= SIZE_RESET;
         pend_ff      <= 1'b0;
         clr_ff       <= '0;
         clr_rsp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         pend_ff      <= pend_in;
         clr_ff       <= clr_in;
         clr_rsp_ff   <= clr_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      waddr_ff      <= waddr_in;
      acc_ff        <= acc_in;
      delta_ff      <= delta_in;
      first_ff      <= first_in;
      val_ff        <= val_in;
      rsp_sum_ff    <= rsp_sum_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_ready     = (state_ff == S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_range_sum = rsp_sum_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

// ===== dv/fenwick_point_set_range_sum_checker.sv =====
`timescale 1ns / 1ps

// Watches the item, result and register channels of the Fenwick block, keeps its own
// tree of partial sums and a copy of every plain value, and compares each result item
// with the answer predicted for the oldest outstanding input item.
module fenwick_point_set_range_sum_checker #(
   parameter int MAX_ENTRIES = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  logic [fwk_pkg::CMD_W-1:0]          req_cmd,
   input  logic [fwk_pkg::IDX_W-1:0]          req_first_index,
   input  logic [fwk_pkg::IDX_W-1:0]          req_last_index,
   input  logic signed [fwk_pkg::DATA_W-1:0]  req_new_value,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic signed [fwk_pkg::DATA_W-1:0]  rsp_range_sum,
   input  logic                               rsp_status,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [fwk_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [31:0]                        pwdata,
   input  logic                               pready,
   output int                                 mismatch_count,
   output int                                 awaiting_count,
   output int                                 answered_count,
   output int                                 flagged_count
);
   import fwk_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] SIZE_ADDR = CSR_ADDR_W'(4 * CSR_IDX_SIZE);

   typedef struct packed {
      logic signed [DATA_W-1:0] range_sum;
      logic                     status;
   } answer_type;

   logic [DATA_W-1:0] tree_sum     [1:MAX_ENTRIES];
   logic [DATA_W-1:0] shadow_value [1:MAX_ENTRIES];
   logic [IDX_W-1:0]  size_setting = SIZE_RESET;
   answer_type        answer_queue [$];
   int                errors   = 0;
   int                answered = 0;
   int                flagged  = 0;

   function automatic void wipe_stores();
      for (int i = 1; i <= MAX_ENTRIES; i++) begin
         tree_sum[i]     = '0;
         shadow_value[i] = '0;
      end
   endfunction

   // Sum of entries 1..pos, walking down by clearing the lowest set bit
   function automatic logic [DATA_W-1:0] prefix_total(int pos);
      logic [DATA_W-1:0] acc;
      int                p;
      acc = '0;
      p   = pos;
      while (p != 0) begin
         if (p <= MAX_ENTRIES) acc += tree_sum[p];
         p = p & (p - 1);
      end
      return acc;
   endfunction

   // Add delta along the upward walk; always runs to MAX_ENTRIES, not to the size
   function automatic void spread_delta(int pos, logic [DATA_W-1:0] delta);
      int p;
      p = pos;
      while (p != 0 && p <= MAX_ENTRIES) begin
         tree_sum[p] += delta;
         p += p & (-p);
      end
   endfunction

   // Apply one item to the tracked state and return the answer it should produce
   function automatic answer_type apply_item(logic [CMD_W-1:0] cmd,
                                             logic [IDX_W-1:0] first_idx,
                                             logic [IDX_W-1:0] last_idx,
                                             logic [DATA_W-1:0] value);
      answer_type ans;
      int         lim;
      ans.range_sum = '0;
      ans.status    = STATUS_DONE;
      lim = (size_setting > MAX_ENTRIES) ? MAX_ENTRIES : int'(size_setting);
      case (cmd)
         CMD_CLEAR: begin
            wipe_stores();
         end
         CMD_SET: begin
            if (first_idx == 0 || first_idx > lim) begin
               ans.status = STATUS_RANGE;
            end else begin
               spread_delta(int'(first_idx), value - shadow_value[first_idx]);
               shadow_value[first_idx] = value;
            end
         end
         CMD_QUERY: begin
            if (first_idx == 0 || first_idx > lim || last_idx == 0 || last_idx > lim) begin
               ans.status = STATUS_RANGE;
            end else begin
               // reversed ranges are not flagged, the difference just wraps
               ans.range_sum = prefix_total(int'(last_idx)) - prefix_total(int'(first_idx) - 1);
            end
         end
         default: ;
      endcase
      return ans;
   endfunction

   // Results are retired before new items are predicted at the same edge
   always @(posedge clock) begin
      answer_type got;
      answer_type want;
      if (reset) begin
         wipe_stores();
         size_setting = SIZE_RESET;
         answer_queue.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.range_sum = rsp_range_sum;
            got.status    = rsp_status;
            if (answer_queue.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("[%0t] unexpected result item: sum %0d status %0b",
                           $time, got.range_sum, got.status);
            end else begin
               want = answer_queue.pop_front();
               answered++;
               if (got.range_sum !== want.range_sum || got.status !== want.status) begin
                  errors++;
                  if (errors <= 10)
                     $display({"[%0t] result mismatch: expected sum %0d status %0b,",
                               " got sum %0d status %0b"},
                              $time, want.range_sum, want.status,
                              got.range_sum, got.status);
               end
            end
         end
         if (req_valid && req_ready) begin
            want = apply_item(req_cmd, req_first_index, req_last_index, req_new_value);
            if (want.status == STATUS_RANGE) flagged++;
            answer_queue.insert(answer_queue.size(), want);
         end
         if (psel && penable && pwrite && pready && paddr == SIZE_ADDR)
            size_setting = pwdata[IDX_W-1:0];
      end
      mismatch_count <= errors;
      awaiting_count <= answer_queue.size();
      answered_count <= answered;
      flagged_count  <= flagged;
   end

endmodule

// ===== dv/fenwick_point_set_range_sum_tb.sv =====
`timescale 1ns / 1ps

module fenwick_point_set_range_sum_tb;
   import fwk_pkg::*;

   localparam int ENTRIES     = 1024;
   localparam int STALL_LIMIT = 20000;
   localparam int PHASE_ITEMS = 160;
   localparam logic [CMD_W-1:0]      CMD_UNUSED = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] SIZE_ADDR  = CSR_ADDR_W'(4 * CSR_IDX_SIZE);

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [CMD_W-1:0]         req_cmd = '0;
   logic [IDX_W-1:0]         req_first_index = '0;
   logic [IDX_W-1:0]         req_last_index = '0;
   logic signed [DATA_W-1:0] req_new_value = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [DATA_W-1:0] rsp_range_sum;
   logic                     rsp_status;
   logic                     psel = 1'b0;
   logic                     penable = 1'b0;
   logic                     pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]    paddr = '0;
   logic [31:0]              pwdata = '0;
   logic [31:0]              prdata;
   logic                     pready;

   int mismatch_count;
   int awaiting_count;
   int answered_count;
   int flagged_count;

   bit               steady = 1'b0;
   logic [IDX_W-1:0] size_now = SIZE_RESET;
   int               items_sent = 0;
   int               clears_sent = 0;
   int               settings_used = 0;
   int               quiet_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   fenwick_point_set_range_sum #(
      .MAX_ENTRIES(ENTRIES)
   ) i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_cmd(req_cmd),
      .req_first_index(req_first_index), .req_last_index(req_last_index),
      .req_new_value(req_new_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_range_sum(rsp_range_sum),
      .rsp_status(rsp_status),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
      .prdata(prdata), .pready(pready)
   );

   fenwick_point_set_range_sum_checker #(
      .MAX_ENTRIES(ENTRIES)
   ) i_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_cmd(req_cmd),
      .req_first_index(req_first_index), .req_last_index(req_last_index),
      .req_new_value(req_new_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_range_sum(rsp_range_sum),
      .rsp_status(rsp_status),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
      .pready(pready),
      .mismatch_count(mismatch_count), .awaiting_count(awaiting_count),
      .answered_count(answered_count), .flagged_count(flagged_count)
   );

   // Idle gaps: mostly none or short, now and then long; none in steady stretches
   function automatic int gap_length();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Mostly in range with the ends favored; some indices of 0 or past the size
   function automatic logic [IDX_W-1:0] pick_index(int lim);
      int r;
      r = $urandom_range(0, 99);
      if (lim == 0 || r < 8) begin
         case ($urandom_range(0, 3))
            0:       return '0;
            1:       return IDX_W'(lim + 1);
            2:       return '1;
            default: return IDX_W'($urandom_range(lim + 1, 2047));
         endcase
      end
      if (r < 20) return IDX_W'(lim);
      if (r < 28) return IDX_W'(1);
      return IDX_W'($urandom_range(1, lim));
   endfunction

   function automatic logic [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2, 3:    return 32'($urandom_range(0, 16)) - 32'd8;
         default: return $urandom();
      endcase
   endfunction

   task automatic send_item(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] first_idx,
                            logic [IDX_W-1:0] last_idx, logic [DATA_W-1:0] value);
      int gap;
      gap = gap_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_first_index <= first_idx;
      req_last_index  <= last_idx;
      req_new_value   <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      if (cmd == CMD_CLEAR) clears_sent++;
   endtask

   // Hold off the sender until every outstanding item has been answered
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaiting_count != 0) @(posedge clock);
   endtask

   task automatic write_size(logic [IDX_W-1:0] value);
      drain();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= SIZE_ADDR;
      pwdata  <= 32'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      size_now = value;
      settings_used++;
   endtask

   task automatic random_item(int lim);
      int r;
      r = $urandom_range(0, 99);
      if (r < 3)
         send_item(CMD_CLEAR, IDX_W'($urandom_range(0, 2047)),
                   IDX_W'($urandom_range(0, 2047)), $urandom());
      else if (r < 5)
         send_item(CMD_UNUSED, IDX_W'($urandom_range(0, 2047)),
                   IDX_W'($urandom_range(0, 2047)), $urandom());
      else if (r < 50)
         send_item(CMD_SET, pick_index(lim), IDX_W'($urandom_range(0, 2047)), pick_value());
      else
         send_item(CMD_QUERY, pick_index(lim), pick_index(lim), pick_value());
   endtask

   // Result side: random back-pressure
   initial begin
      int stall;
      @(posedge clock);
      forever begin
         stall = gap_length();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   end

   // Watchdog on cycles where no channel moves anything
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (psel && penable && pwrite && pready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Timeout: nothing moved for %0d cycles", STALL_LIMIT);
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      logic [IDX_W-1:0] phase_size [9];
      int               lim;
      int               count;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extreme values and indices at the reset size of 1024
      send_item(CMD_SET, 11'd1, 11'd0, 32'h7FFF_FFFF);
      send_item(CMD_SET, 11'd1024, 11'd2047, 32'h8000_0000);
      send_item(CMD_SET, 11'd512, 11'd0, 32'hFFFF_FFFF);
      send_item(CMD_SET, 11'd0, 11'd0, 32'd123);
      send_item(CMD_SET, 11'd1025, 11'd0, 32'd77);
      send_item(CMD_QUERY, 11'd1, 11'd1024, 32'd0);
      send_item(CMD_QUERY, 11'd1024, 11'd1, 32'd0);
      send_item(CMD_QUERY, 11'd0, 11'd2047, 32'd0);
      send_item(CMD_QUERY, 11'd5, 11'd0, 32'd0);
      send_item(CMD_SET, 11'd1, 11'd0, 32'd5);
      send_item(CMD_QUERY, 11'd1, 11'd512, 32'd0);
      send_item(CMD_UNUSED, 11'd2047, 11'd2047, 32'hFFFF_FFFF);
      send_item(CMD_CLEAR, 11'd0, 11'd0, 32'd0);
      send_item(CMD_QUERY, 11'd1, 11'd1024, 32'd0);

      // Directed: one entry, no entries, and a size beyond the store
      write_size(11'd1);
      send_item(CMD_SET, 11'd1, 11'd0, 32'hFFFF_FFF9);
      send_item(CMD_SET, 11'd2, 11'd0, 32'd3);
      send_item(CMD_QUERY, 11'd1, 11'd1, 32'd0);
      send_item(CMD_QUERY, 11'd1, 11'd2, 32'd0);
      write_size(11'd0);
      send_item(CMD_SET, 11'd1, 11'd0, 32'd9);
      send_item(CMD_QUERY, 11'd1, 11'd1, 32'd0);
      write_size(11'd2047);
      send_item(CMD_SET, 11'd1024, 11'd0, 32'd42);
      send_item(CMD_QUERY, 11'd1, 11'd1024, 32'd0);
      send_item(CMD_QUERY, 11'd1025, 11'd1025, 32'd0);

      // Random phases, each under its own size setting
      phase_size = '{11'd1024, 11'd9, 11'd1, 11'd2047, IDX_W'($urandom_range(3, 1024)),
                     11'd2, 11'd1023, 11'd0, IDX_W'($urandom_range(3, 1024))};
      for (int ph = 0; ph < 9; ph++) begin
         write_size(phase_size[ph]);
         steady = (ph % 3 == 1);
         lim    = (size_now > ENTRIES) ? ENTRIES : int'(size_now);
         count  = (phase_size[ph] == 0) ? 20 : PHASE_ITEMS;
         for (int n = 0; n < count; n++) random_item(lim);
      end
      steady = 1'b0;

      drain();
      repeat (40) @(posedge clock);
      $display("Ran %0d items (%0d clears) under %0d size settings, from 0 up to 2047.",
               items_sent, clears_sent, settings_used);
      $display("Checked %0d result items, %0d of them flagged out of range.",
               answered_count, flagged_count);
      if (mismatch_count == 0 && awaiting_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/fwk_pkg.sv
hdl/fwk_store.sv
hdl/fenwick_point_set_range_sum.sv
dv/fenwick_point_set_range_sum_checker.sv
dv/fenwick_point_set_range_sum_tb.sv
